// ===== design/vps_pkg.sv =====
// vps_pkg: shared constants, codes and types for the valve pulse sequencer
// no dependencies; used by vps_queue and valve_pulse_sequencer
`default_nettype none

package vps_pkg;

  // default sizing
  localparam int ZONE_COUNT_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // settle time added to every pulse, in milliseconds
  localparam logic [16:0] SETTLE_MS = 17'd50;

  // field widths
  localparam int WIDTH_W = 16;
  localparam int REM_W   = 17;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_ZONE_SET  = 2'd1;
  localparam logic [1:0] REQ_STOP_ALL  = 2'd2;
  localparam logic [1:0] REQ_TEST_MODE = 2'd3;

  // configuration register indexes
  localparam logic [7:0] CFG_PULSE_WIDTH    = 8'd0;
  localparam logic [7:0] CFG_CLOSE_ALL_BOOT = 8'd1;

  // queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } vps_qctl_t;

endpackage

`default_nettype wire

// ===== design/vps_queue.sv =====
// vps_queue: circular command queue with registered read of the head entry
// depends on vps_pkg for the control struct
`default_nettype none

module vps_queue #(
  parameter int DEPTH = vps_pkg::QUEUE_DEPTH_DEF,
  parameter int EW    = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire vps_pkg::vps_qctl_t          ctl,
  input  wire logic [EW-1:0]               wr_data,
  output logic      [EW-1:0]               rd_data,
  output logic      [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;

  // storage and head read, data is registered from the head address
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail  <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
        count <= count + CW'(1);
      end else if (ctl.pop) begin
        head  <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/valve_pulse_sequencer.sv =====
// valve_pulse_sequencer: paced valve command queue with pump interlock
// depends on vps_pkg and vps_queue
//
// usage
//   s_* channel: one request per transaction, kind in s_tuser (tick, zone
//   set, stop all, pump test), zone / direction / test mode in s_tdata.
//   m_* channel: exactly one result transaction per request, holding the
//   command issued (if any), pump state, open zone map, drop flag and level.
//   cfg_* channel: register writes (pulse width, close-all at boot), ready
//   whenever reset is low; the user must write them only while the block is
//   idle, which the block itself does not enforce.
// timing
//   a zone set, pump test or tick that issues nothing passes through dispatch
//   and result load; a tick that issues adds the head pop; a stop-all adds a
//   close-all run, with closes pushed one zone per cycle through the single
//   queue write port; the first request after reset adds another close-all
//   run when close-all at boot is set. s_tready returns once the result is
//   loaded, so a new request is taken only once the last result is loaded.
// reset
//   queue empty, all zones closed, pump off, not busy, boot sequence armed.
// stall
//   the result sits in an output register; the next request can be taken
//   while it waits, but its own result is held back until the slot frees.
`default_nettype none

module valve_pulse_sequencer #(
  parameter int ZONE_COUNT  = vps_pkg::ZONE_COUNT_DEF,
  parameter int QUEUE_DEPTH = vps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // zone[7:0], open_valve[8], test_mode[9], zero pad
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // cmd_zone[3:0], cmd_open[4], cmd_width_ms[20:5],
                                      // pump_on[21], open_zones[29:22],
                                      // queue_dropped[30], queue_level[35:31], zero pad
  output logic [0:0]       m_tuser,   // cmd_valid[0]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // zone index (zone - 1) width and queue entry layout {width, open, index}
  localparam int ZIW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int EW  = vps_pkg::WIDTH_W + 1 + ZIW;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_ALL,
    S_DISPATCH,
    S_POP,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [15:0] pulse_width_ms;
  logic        close_all_on_boot;

  // captured request
  logic [1:0]  req_type;
  logic [7:0]  req_zone;
  logic        req_open;
  logic        req_test;

  // block state
  logic                 boot_pending;
  logic                 boot_phase;     // close-all run belongs to the boot sequence
  logic [ZIW-1:0]       zone_ctr;
  logic                 busy;
  logic [16:0]          remaining_ms;
  logic [ZONE_COUNT-1:0] zone_map;
  logic                 test_mode;
  logic                 pump_state;

  // result being built
  logic                 res_valid;
  logic [3:0]           res_zone;
  logic                 res_open;
  logic [15:0]          res_width;
  logic                 res_dropped;

  // queue interface
  vps_pkg::vps_qctl_t   qctl;
  logic [EW-1:0]        q_wr;
  logic [EW-1:0]        q_rd;
  logic [CW-1:0]        q_count;
  logic                 q_full;

  // head entry fields
  logic [ZIW-1:0]       head_zidx;
  logic                 head_open;
  logic [15:0]          head_width;

  // shared 17-bit adder: tick countdown or width plus settle time
  logic [16:0]          add_a;
  logic [16:0]          add_b;
  logic [16:0]          add_sum;

  logic                 zone_ok;
  logic                 busy_after;
  logic [ZONE_COUNT-1:0] map_next;
  logic                 out_free;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;

  assign q_full    = (q_count == CW'(QUEUE_DEPTH));
  assign zone_ok   = (req_zone != 8'd0) && (req_zone <= 8'(ZONE_COUNT));

  assign head_zidx  = q_rd[ZIW-1:0];
  assign head_open  = q_rd[ZIW];
  assign head_width = q_rd[EW-1 -: vps_pkg::WIDTH_W];

  // countdown ends the busy period when it reaches zero
  assign busy_after = busy && (remaining_ms > 17'd1);

  always_comb begin
    map_next            = zone_map;
    map_next[head_zidx] = head_open;
  end

  always_comb begin
    if (state == S_POP) begin
      add_a = {1'b0, head_width};
      add_b = vps_pkg::SETTLE_MS;
    end else begin
      add_a = remaining_ms;
      add_b = '1;
    end
    add_sum = add_a + add_b;
  end

  // queue writes: close-all pushes one zone a cycle, zone set pushes once
  always_comb begin
    qctl = '0;
    q_wr = {pulse_width_ms, 1'b0, zone_ctr};
    unique case (state)
      S_PUSH_ALL: begin
        qctl.push = !q_full;
      end
      S_DISPATCH: begin
        if (req_type == vps_pkg::REQ_ZONE_SET) begin
          qctl.push = zone_ok && !q_full;
          q_wr      = {pulse_width_ms, req_open, ZIW'(req_zone - 8'd1)};
        end
      end
      S_POP: begin
        qctl.pop = 1'b1;
      end
      default: begin
      end
    endcase
  end

  vps_queue #(
    .DEPTH (QUEUE_DEPTH),
    .EW    (EW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .wr_data (q_wr),
    .rd_data (q_rd),
    .count   (q_count)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_ms    <= '0;
      close_all_on_boot <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == vps_pkg::CFG_PULSE_WIDTH) begin
        pulse_width_ms <= cfg_data;
      end else if (cfg_index == vps_pkg::CFG_CLOSE_ALL_BOOT) begin
        close_all_on_boot <= cfg_data[0];
      end
    end
  end

  // captured request payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_type <= s_tuser;
      req_zone <= s_tdata[7:0];
      req_open <= s_tdata[8];
      req_test <= s_tdata[9];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      boot_pending   <= 1'b1;
      boot_phase     <= 1'b0;
      zone_ctr       <= '0;
      busy           <= 1'b0;
      remaining_ms   <= '0;
      zone_map       <= '0;
      test_mode      <= 1'b0;
      pump_state     <= 1'b0;
      res_valid      <= 1'b0;
      res_zone       <= '0;
      res_open       <= 1'b0;
      res_width      <= '0;
      res_dropped    <= 1'b0;
      m_tvalid       <= 1'b0;
      m_tdata        <= '0;
      m_tuser        <= '0;
    end else begin
      // the finish state reloads the slot itself
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_valid   <= 1'b0;
            res_zone    <= '0;
            res_open    <= 1'b0;
            res_width   <= '0;
            res_dropped <= 1'b0;
            zone_ctr    <= '0;
            if (boot_pending) begin
              boot_pending <= 1'b0;
            end
            if (boot_pending && close_all_on_boot) begin
              boot_phase <= 1'b1;
              state      <= S_PUSH_ALL;
            end else begin
              state <= S_DISPATCH;
            end
          end
        end
        S_PUSH_ALL: begin
          if (q_full) begin
            res_dropped <= 1'b1;
          end
          zone_ctr <= zone_ctr + ZIW'(1);
          if (zone_ctr == ZIW'(ZONE_COUNT - 1)) begin
            state <= boot_phase ? S_DISPATCH : S_FINISH;
          end
        end
        S_DISPATCH: begin
          boot_phase <= 1'b0;
          zone_ctr   <= '0;
          unique case (req_type)
            vps_pkg::REQ_ZONE_SET: begin
              if (zone_ok && q_full) begin
                res_dropped <= 1'b1;
              end
              state <= S_FINISH;
            end
            vps_pkg::REQ_STOP_ALL: begin
              state <= S_PUSH_ALL;
            end
            vps_pkg::REQ_TEST_MODE: begin
              test_mode <= req_test;
              state     <= S_FINISH;
            end
            vps_pkg::REQ_TICK: begin
              if (busy) begin
                remaining_ms <= (remaining_ms != 17'd0) ? add_sum : remaining_ms;
                busy         <= busy_after;
              end
              if (!busy_after && (q_count != '0)) begin
                state <= S_POP;
              end else begin
                pump_state <= (|zone_map) || test_mode;
                state      <= S_FINISH;
              end
            end
          endcase
        end
        S_POP: begin
          res_valid    <= 1'b1;
          res_zone     <= 4'({1'b0, head_zidx} + (ZIW + 1)'(1));
          res_open     <= head_open;
          res_width    <= head_width;
          zone_map     <= map_next;
          busy         <= 1'b1;
          remaining_ms <= add_sum;
          pump_state   <= (|map_next) || test_mode;
          state        <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tuser[0] <= res_valid;
            m_tdata    <= {4'd0, 5'(q_count), res_dropped, 8'(zone_map), pump_state,
                           res_width, res_open, res_zone};
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
